/* src/uf_pkg.sv */
// shared constants, types and states of the union-find join engine
package uf_pkg;

  localparam int NODES    = 1024;
  localparam int NODE_W   = $clog2(NODES);
  localparam int IN_W     = 10;
  localparam int RANK_W   = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  // a root walk visits at most log2(NODES) non-root nodes
  localparam int PIDX_W   = $clog2(NODE_W + 1);
  localparam int PATH_D   = 2 ** PIDX_W;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  // write beat broadcast to every lane's copy of the tables
  typedef struct packed {
    logic  par_we;
    node_t par_addr;
    node_t par_data;
    logic  rank_we;
    node_t rank_addr;
    rank_t rank_data;
  } wr_t;

  // what one lane found
  typedef struct packed {
    logic  busy;
    node_t root;
    rank_t rank;
    pidx_t cnt;
  } lane_stat_t;

  // link decision from the merging stage
  typedef struct packed {
    logic  same;
    node_t par_addr;
    node_t par_data;
    logic  rank_we;
    node_t rank_addr;
    rank_t rank_data;
  } link_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIXA,
    ST_FIXB,
    ST_LINK,
    ST_DONE
  } state_t;

endpackage

/* src/union_find_join_core.sv */
// union-find join engine: two walk lanes, merging stage and write-back control
// sequence per in-range beat: both lanes walk to their roots side by side, then the recorded paths
//   of a and b are compressed in turn (each walk depth <= log2 NODES); one parent step per cycle per lane
//   and one compression write per cycle, then the link write and the hand-off
// one beat at a time: a new beat is taken only once the previous result has been handed off
// reset: a clearing pass rewrites every parent to itself and every rank to zero
module union_find_join_core
  import uf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_node_a,
  input  logic [IN_W-1:0] in_node_b,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_joined
);

  state_t     state_r, state_nxt;
  node_t      clr_r, clr_nxt;
  pidx_t      fix_r, fix_nxt;
  logic       joined_r, joined_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_joined_r, out_joined_nxt;
  logic       in_acc, in_rng, start;
  wr_t        wr;
  lane_stat_t stat_a, stat_b;
  node_t      path_a, path_b;
  link_t      link;

  assign in_acc = in_valid && !in_stall;
  assign in_rng = (32'(in_node_a) < NODES) && (32'(in_node_b) < NODES);
  assign start  = in_acc && in_rng;

  uf_lane u_lane_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .node      (node_t'(in_node_a)),
    .wr        (wr),
    .pidx      (fix_r),
    .path_node (path_a),
    .stat      (stat_a)
  );

  uf_lane u_lane_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .node      (node_t'(in_node_b)),
    .wr        (wr),
    .pidx      (fix_r),
    .path_node (path_b),
    .stat      (stat_b)
  );

  uf_merge u_merge (
    .stat_a (stat_a),
    .stat_b (stat_b),
    .link   (link)
  );

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      fix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fix_r       <= fix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    joined_r     <= joined_nxt;
    out_joined_r <= out_joined_nxt;
  end

  // sequencer: clear, walk, compress, link, hand off
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    fix_nxt        = fix_r;
    joined_nxt     = joined_r;
    out_joined_nxt = out_joined_r;
    out_valid_nxt  = out_valid_r && out_stall;
    in_stall       = 1'b1;
    wr             = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr.par_we    = 1'b1;
        wr.par_addr  = clr_r;
        wr.par_data  = clr_r;
        wr.rank_we   = 1'b1;
        wr.rank_addr = clr_r;
        wr.rank_data = '0;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == node_t'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        fix_nxt    = '0;
        joined_nxt = 1'b0;
        if (in_valid) begin
          state_nxt = in_rng ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (!stat_a.busy && !stat_b.busy) begin
          state_nxt = ST_FIXA;
        end
      end
      ST_FIXA: begin
        if (fix_r == stat_a.cnt) begin
          fix_nxt   = '0;
          state_nxt = ST_FIXB;
        end else begin
          wr.par_we   = 1'b1;
          wr.par_addr = path_a;
          wr.par_data = stat_a.root;
          fix_nxt     = fix_r + 1'b1;
        end
      end
      ST_FIXB: begin
        if (fix_r == stat_b.cnt) begin
          fix_nxt   = '0;
          state_nxt = ST_LINK;
        end else begin
          wr.par_we   = 1'b1;
          wr.par_addr = path_b;
          wr.par_data = stat_b.root;
          fix_nxt     = fix_r + 1'b1;
        end
      end
      ST_LINK: begin
        wr.par_we    = !link.same;
        wr.par_addr  = link.par_addr;
        wr.par_data  = link.par_data;
        wr.rank_we   = link.rank_we;
        wr.rank_addr = link.rank_addr;
        wr.rank_data = link.rank_data;
        joined_nxt   = !link.same;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_joined_nxt = joined_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_joined = out_joined_r;

  // lanes are finished before any write-back
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIXA || state_r == ST_FIXB || state_r == ST_LINK)
      |-> (!stat_a.busy && !stat_b.busy))
    else $error("write-back while a lane still walks");

  // recorded path never exceeds the rank-bounded depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (32'(stat_a.cnt) <= NODE_W) && (32'(stat_b.cnt) <= NODE_W))
    else $error("walk path longer than log2 of node count");

  // an in-range beat starts both walks
  assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_WALK && stat_a.busy && stat_b.busy))
    else $error("accepted beat did not start the lanes");

  // a result appears only after the hand-off state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside hand-off");

endmodule

/* src/uf_ram.sv */
// generic single-write, single-read ram with registered read data
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/uf_lane.sv */
// one root-walk lane: own copy of parent and rank tables plus its path buffer
module uf_lane
  import uf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  node_t      node,
  input  wr_t        wr,
  input  pidx_t      pidx,
  output node_t      path_node,
  output lane_stat_t stat
);

  node_t par_rd;
  rank_t rank_rd;
  node_t raddr;
  node_t cur_r;
  logic  busy_r;
  node_t root_r;
  rank_t rank_r;
  pidx_t cnt_r;
  node_t path_r [PATH_D];

  // next read follows the parent just returned
  assign raddr = busy_r ? par_rd : node;

  uf_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_par (
    .clk   (clk),
    .we    (wr.par_we),
    .waddr (wr.par_addr),
    .wdata (wr.par_data),
    .raddr (raddr),
    .rdata (par_rd)
  );

  uf_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
    .clk   (clk),
    .we    (wr.rank_we),
    .waddr (wr.rank_addr),
    .wdata (wr.rank_data),
    .raddr (raddr),
    .rdata (rank_rd)
  );

  // walk control, one parent step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (par_rd == cur_r) begin
        busy_r <= 1'b0;
      end else if (cnt_r != pidx_t'(PATH_D - 1)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r <= node;
    end else if (busy_r) begin
      if (par_rd == cur_r) begin
        root_r <= cur_r;
        rank_r <= rank_rd;
      end else begin
        path_r[cnt_r] <= cur_r;
        cur_r         <= par_rd;
      end
    end
  end

  assign path_node = path_r[pidx];

  always_comb begin
    stat.busy = busy_r;
    stat.root = root_r;
    stat.rank = rank_r;
    stat.cnt  = cnt_r;
  end

endmodule

/* src/uf_merge.sv */
// merging stage: compares the two roots and picks the link and rank update
module uf_merge
  import uf_pkg::*;
(
  input  lane_stat_t stat_a,
  input  lane_stat_t stat_b,
  output link_t      link
);

  // union by rank, ties hang b's root under a's
  always_comb begin
    link.same      = (stat_a.root == stat_b.root);
    link.rank_addr = stat_a.root;
    link.rank_data = stat_a.rank + 1'b1;
    if (stat_a.rank < stat_b.rank) begin
      link.par_addr = stat_a.root;
      link.par_data = stat_b.root;
      link.rank_we  = 1'b0;
    end else begin
      link.par_addr = stat_b.root;
      link.par_data = stat_a.root;
      link.rank_we  = !link.same && (stat_a.rank == stat_b.rank)
                      && (stat_a.rank != RANK_MAX);
    end
  end

endmodule
